// File: design/i8mm_pkg.sv
// Shared types and constants for the int8 matrix multiply core.
// No dependencies; every other design file imports this package.
package i8mm_pkg;

   // command codes on the request tuser
   localparam logic [1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // register indexes on the csr channel
   localparam logic [1:0] CSR_ROWS  = 2'd0;
   localparam logic [1:0] CSR_COLS  = 2'd1;
   localparam logic [1:0] CSR_DEPTH = 2'd2;

   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;
   localparam int SUM_W      = 24;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPW         = $clog2(QUEUE_DEPTH);
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_LOAD_A,
      KIND_LOAD_B,
      KIND_RUN,
      KIND_FAULT
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [7:0]        row;
      logic [7:0]        col;
      logic signed [7:0] element;
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } back_state_type;

endpackage

// File: design/i8mm_front.sv
// Front end: request intake, register file and command classification.
// Depends on i8mm_pkg; pushes classified words into i8mm_queue.
module i8mm_front #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16,
   parameter int MAX_DEPTH = 256,
   localparam int KW = $clog2(MAX_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [i8mm_pkg::REQ_DATA_W-1:0]     req_tdata,  // row, col, element
   input  logic [1:0]                          req_tuser,  // cmd
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [i8mm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                q_full,
   output logic                                q_push,
   output i8mm_pkg::op_type                    q_op,
   output logic [KW-1:0]                       depth_eff
);
   import i8mm_pkg::*;

   logic [4:0] rows_ff, rows_in;
   logic [4:0] cols_ff, cols_in;
   logic [8:0] depth_ff, depth_in;
   logic [8:0] rows_eff, cols_eff;
   logic [7:0] row_w, col_w;
   logic       keep;

   assign csr_ready = 1'b1;

   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      depth_in = depth_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROWS:  rows_in  = csr_data[4:0];
            CSR_COLS:  cols_in  = csr_data[4:0];
            CSR_DEPTH: depth_in = csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= 5'd16;
         cols_ff  <= 5'd16;
         depth_ff <= 9'd256;
      end else begin
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         depth_ff <= depth_in;
      end
   end

   // registers saturate at the store dimensions
   assign rows_eff  = (32'(rows_ff) > MAX_ROWS) ? 9'(MAX_ROWS) : 9'(rows_ff);
   assign cols_eff  = (32'(cols_ff) > MAX_COLS) ? 9'(MAX_COLS) : 9'(cols_ff);
   assign depth_eff = (32'(depth_ff) > MAX_DEPTH) ? KW'(MAX_DEPTH) : KW'(depth_ff);

   assign row_w = req_tdata[7:0];
   assign col_w = req_tdata[15:8];

   always_comb begin
      keep         = 1'b0;
      q_op.kind    = KIND_RUN;
      q_op.row     = row_w;
      q_op.col     = col_w;
      q_op.element = req_tdata[23:16];
      case (req_tuser)
         CMD_LOAD_A: begin
            q_op.kind = KIND_LOAD_A;
            keep      = (32'(row_w) < MAX_ROWS) && (32'(col_w) < MAX_DEPTH);
         end
         CMD_LOAD_B: begin
            q_op.kind = KIND_LOAD_B;
            keep      = (32'(row_w) < MAX_DEPTH) && (32'(col_w) < MAX_COLS);
         end
         CMD_COMPUTE: begin
            keep = 1'b1;
            if (({1'b0, row_w} >= rows_eff) || ({1'b0, col_w} >= cols_eff)) begin
               q_op.kind = KIND_FAULT;
            end
         end
         default: keep = 1'b0;  // unused command, dropped
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && keep;

endmodule

// File: design/i8mm_queue.sv
// Short queue of classified words between the front and back ends.
// Depends on i8mm_pkg for the word type and depth.
module i8mm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  i8mm_pkg::op_type op_in,
   input  logic             pop,
   output i8mm_pkg::op_type op_out,
   output logic             full,
   output logic             empty
);
   import i8mm_pkg::*;

   op_type         q_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           do_push, do_pop;

   assign full    = (count_ff == QCW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign op_out  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule

// File: design/i8mm_back.sv
// Back end: A/B element stores, multiply-accumulate walk and result register.
// Depends on i8mm_pkg; takes words from i8mm_queue.
module i8mm_back #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16,
   parameter int MAX_DEPTH = 256,
   localparam int KW = $clog2(MAX_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  i8mm_pkg::op_type                q_op,
   output logic                            q_pop,
   input  logic [KW-1:0]                   depth_eff,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [i8mm_pkg::RSP_DATA_W-1:0] rsp_tdata   // row, col, sum, status
);
   import i8mm_pkg::*;

   localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
   localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
   localparam int AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

   logic signed [7:0] a_mem [A_DEPTH];
   logic signed [7:0] b_mem [B_DEPTH];

   back_state_type state_ff, state_in;
   logic [AAW-1:0] a_addr_ff, a_addr_in;
   logic [BAW-1:0] b_addr_ff, b_addr_in;
   logic [KW-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [7:0]     row_ff, row_in, col_ff, col_in;
   logic           status_ff, status_in;

   logic signed [7:0]  a_rd_ff, b_rd_ff;
   logic signed [15:0] prod_ff;
   logic rd_vld_ff, rd_last_ff, prod_vld_ff, prod_last_ff;
   logic issue, last_issue, out_load;

   logic [AAW-1:0] a_wr_addr, a_base;
   logic [BAW-1:0] b_wr_addr;

   logic             out_vld_ff, out_vld_in;
   logic [7:0]       out_row_ff, out_col_ff;
   logic [SUM_W-1:0] out_sum_ff;
   logic             out_status_ff;

   assign a_wr_addr = AAW'(32'(q_op.row) * MAX_DEPTH + 32'(q_op.col));
   assign b_wr_addr = BAW'(32'(q_op.row) * MAX_COLS + 32'(q_op.col));
   assign a_base    = AAW'(32'(q_op.row) * MAX_DEPTH);
   assign last_issue = issue && (cnt_ff == KW'(1));

   always_comb begin
      state_in  = state_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      cnt_in    = cnt_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      status_in = status_ff;
      acc_in    = prod_vld_ff ? acc_ff + SUM_W'(prod_ff) : acc_ff;
      issue     = 1'b0;
      out_load  = 1'b0;
      q_pop     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_op.kind)
                  KIND_RUN: begin
                     row_in    = q_op.row;
                     col_in    = q_op.col;
                     status_in = 1'b0;
                     acc_in    = '0;
                     a_addr_in = a_base;
                     b_addr_in = BAW'(q_op.col);
                     cnt_in    = depth_eff;
                     state_in  = (depth_eff == '0) ? ST_DONE : ST_MAC;
                  end
                  KIND_FAULT: begin
                     row_in    = q_op.row;
                     col_in    = q_op.col;
                     status_in = 1'b1;
                     acc_in    = '0;
                     state_in  = ST_DONE;
                  end
                  default: ;  // loads are written below
               endcase
            end
         end
         ST_MAC: begin
            issue     = 1'b1;
            a_addr_in = a_addr_ff + AAW'(1);
            b_addr_in = b_addr_ff + BAW'(MAX_COLS);
            cnt_in    = cnt_ff - KW'(1);
            if (cnt_ff == KW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (prod_vld_ff && prod_last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_vld_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      status_ff <= status_in;
   end

   // element stores: one write, one registered read each
   always_ff @(posedge clock) begin
      if (q_pop && (q_op.kind == KIND_LOAD_A)) begin
         a_mem[a_wr_addr] <= q_op.element;
      end
      a_rd_ff <= a_mem[a_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (q_pop && (q_op.kind == KIND_LOAD_B)) begin
         b_mem[b_wr_addr] <= q_op.element;
      end
      b_rd_ff <= b_mem[b_addr_ff];
   end

   // read -> multiply -> accumulate
   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= issue;
         rd_last_ff   <= last_issue;
         prod_vld_ff  <= rd_vld_ff;
         prod_last_ff <= rd_last_ff;
      end
   end

   // result register
   assign out_vld_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_row_ff    <= row_ff;
         out_col_ff    <= col_ff;
         out_sum_ff    <= acc_ff;
         out_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'b0, out_status_ff, out_sum_ff, out_col_ff, out_row_ff};

   a_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> cnt_ff != '0)
      else $error("MAC walk entered with zero count");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rd_vld_ff && !prod_vld_ff)
      else $error("product pipeline busy while idle");

   a_last_in_drain: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff && prod_last_ff |-> state_ff == ST_DRAIN)
      else $error("last product arrived outside drain");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded without finished compute");

endmodule

// File: design/int8_matrix_multiply_core.sv
// Top level of the int8 matrix multiply core with 24-bit sums.
// Depends on i8mm_pkg, i8mm_front, i8mm_queue and i8mm_back.
//
//   port group   direction  word contents (low bit first)
//   req_*        in         tdata: row_index[7:0] col_index[15:8] element[23:16];
//                           tuser: cmd[1:0]
//   rsp_*        out        tdata: out_row[7:0] out_col[15:8] sum[39:16] status[40]
//   csr_*        in         index 0 rows_m, 1 cols_n, 2 depth_k; data[8:0]
//
// Loads are written into the stores as they are popped. A compute word issues
// one multiply-accumulate per cycle on the single read port of each store,
// then passes read, multiply and result stages. Errors and zero depth skip the walk.
// Reset is synchronous; the stores are not cleared and need no clearing pass.
// The request side keeps taking words into a four-word queue while a compute
// runs; a stalled result holds in the output register without blocking loads.
module int8_matrix_multiply_core #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16,
   parameter int MAX_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [i8mm_pkg::REQ_DATA_W-1:0] req_tdata,  // row_index, col_index, element
   input  logic [1:0]                      req_tuser,  // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [i8mm_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_row, out_col, sum, status, pad
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [i8mm_pkg::CSR_DATA_W-1:0] csr_data
);
   import i8mm_pkg::*;

   localparam int KW = $clog2(MAX_DEPTH + 1);

   logic          q_push, q_pop, q_full, q_empty;
   op_type        q_in, q_out;
   logic [KW-1:0] depth_eff;

   i8mm_front #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (q_in),
      .depth_eff  (depth_eff)
   );

   i8mm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .op_in  (q_in),
      .pop    (q_pop),
      .op_out (q_out),
      .full   (q_full),
      .empty  (q_empty)
   );

   i8mm_back #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_op       (q_out),
      .q_pop      (q_pop),
      .depth_eff  (depth_eff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
